/* hdl/mf3_pkg.sv */
// Shared types and constants for the 3x3 median filter.
// No dependencies; every other file imports this package.
package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_DATA_W     = 12;
  localparam int CFG_IDX_W      = 1;
  localparam int MIN_DIM        = 3;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  // output buffer and the number of pipeline slots that feed it
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int PIPE_SLOTS     = 5;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  // 3x3 window, index row*3+col; row 0 is the oldest line, col 0 the oldest column
  typedef pix_t [8:0] win_t;

  // per-word control from the sequencer into the line store
  typedef struct packed {
    logic shift;   // word moves the window (pixel in frame, or drain once the frame is in)
    logic wr;      // word writes the line store
    logic emit;    // word produces an output
    logic border;  // output position lies on the frame border
    logic last;    // output position is the last of the frame
    pix_t pix;
  } step_t;

  // control carried along with an output word through the sorter
  typedef struct packed {
    logic valid;
    logic border;
    logic last;
  } tag_t;

  typedef struct packed {
    pix_t pixel_out;
    logic frame_end;
  } out_word_t;

endpackage

/* hdl/mf3_stream_if.sv */
// Stream interfaces for the median filter input and output channels.
// Depends on mf3_pkg for the pixel type.
interface mf3_in_if import mf3_pkg::*; ();
  logic valid;
  logic ready;
  logic opcode;
  pix_t pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

interface mf3_out_if import mf3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

/* hdl/mf3_ctrl.sv */
// Sequencer: frame size registers, input/output raster counters, word classification.
// Depends on mf3_pkg and mf3_in_if.
module mf3_ctrl import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  mf3_in_if.sink                       in_s,
  input  logic                         room_i,
  output step_t                        step_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);  // input row runs one past the frame on drain
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  logic [WW-1:0]  w_q, w_d, w_clamp;
  logic [HW-1:0]  h_q, h_d, h_clamp;
  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [ORW-1:0] out_row_q, out_row_d;
  int unsigned    cfg_val;

  logic accept, is_drain, in_done, primed;
  logic shift, wr, emit, border, last;
  logic col_end, out_col_end, out_row_end;

  // clamp written sizes to the supported range
  always_comb begin
    cfg_val = 32'(cfg_data_i);
    if (cfg_val < MIN_DIM) begin
      w_clamp = WW'(MIN_DIM);
    end else if (cfg_val > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_val);
    end
    if (cfg_val < MIN_DIM) begin
      h_clamp = HW'(MIN_DIM);
    end else if (cfg_val > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_val);
    end
  end

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  w_d = w_clamp;
        CFG_FRAME_HEIGHT: h_d = h_clamp;
        default: ;
      endcase
    end
  end

  // word classification
  assign in_s.ready  = room_i;
  assign accept      = in_s.valid && in_s.ready;
  assign is_drain    = (opcode_e'(in_s.opcode) == OP_DRAIN);
  assign in_done     = (in_row_q >= RW'(h_q));
  // output lags input by width+1 positions
  assign primed      = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign shift       = accept && (is_drain ? in_done : !in_done);
  assign wr          = accept && !is_drain && !in_done;
  assign emit        = accept && (is_drain ? in_done : (!in_done && primed));

  assign col_end     = (in_col_q == CW'(w_q - WW'(1)));
  assign out_col_end = (out_col_q == CW'(w_q - WW'(1)));
  assign out_row_end = (out_row_q == ORW'(h_q - HW'(1)));
  assign border      = (out_row_q == '0) || (out_col_q == '0) || out_row_end || out_col_end;
  assign last        = out_row_end && out_col_end;

  // raster counters; drains keep the input counter running past the frame
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (shift) begin
      if (col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end
    if (emit) begin
      if (out_col_end) begin
        out_col_d = '0;
        out_row_d = out_row_q + ORW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
    // end of frame or size change restarts the frame
    if ((emit && last) || cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WW'(W_RST);
      h_q       <= HW'(H_RST);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign step_o = '{shift: shift, wr: wr, emit: emit, border: border, last: last,
                    pix: in_s.pixel_in};
  assign col_o  = in_col_q;

endmodule

/* hdl/mf3_line_store.sv */
// Two column-indexed line memories and the 3x3 window register.
// Depends on mf3_pkg.
module mf3_line_store import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  step_t                        step_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  output win_t                         win_o,
  output tag_t                         tag_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  // line1 holds the previous row, line2 the row before it
  pix_t line1_mem [MAX_WIDTH];
  pix_t line2_mem [MAX_WIDTH];

  pix_t          rd1_q, rd2_q;
  step_t         s1_q;
  logic [CW-1:0] s1_col_q;
  win_t          win_q, win_d;
  tag_t          tag_q, tag_d;

  // line1: read old value and write the new pixel at the same column
  always_ff @(posedge clk_i) begin
    if (step_i.shift) begin
      rd1_q <= line1_mem[col_i];
      if (step_i.wr) begin
        line1_mem[col_i] <= step_i.pix;
      end
    end
  end

  // line2: read now, written in the following cycle with the value leaving line1
  always_ff @(posedge clk_i) begin
    if (step_i.shift) begin
      rd2_q <= line2_mem[col_i];
    end
    if (s1_q.shift && s1_q.wr) begin
      line2_mem[s1_col_q] <= rd1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q <= col_i;
  end

  // window shifts left by one column per shifting word
  always_comb begin
    win_d = win_q;
    if (s1_q.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]     = win_q[r*3 + 1];
        win_d[r*3 + 1] = win_q[r*3 + 2];
      end
      win_d[2] = rd2_q;
      win_d[5] = rd1_q;
      win_d[8] = s1_q.pix;
    end
    tag_d = '{valid: s1_q.shift && s1_q.emit, border: s1_q.border, last: s1_q.last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      win_q <= '0;
      tag_q <= '0;
    end else begin
      s1_q  <= step_i;
      win_q <= win_d;
      tag_q <= tag_d;
    end
  end

  assign win_o = win_q;
  assign tag_o = tag_q;

endmodule

/* hdl/mf3_median.sv */
// Two-stage median-of-nine network: column sorts, then max/median/min of the rows.
// Depends on mf3_pkg.
module mf3_median import mf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  win_t      win_i,
  input  tag_t      tag_i,
  output logic      wr_o,
  output out_word_t word_o
);

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo_q [3];
  pix_t mid_q [3];
  pix_t hi_q [3];
  pix_t ctr_a_q, ctr_b_q;
  pix_t mx_q, md_q, mn_q;
  tag_t tag_a_q, tag_b_q;

  // stage A: sort each column
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      lo_q[c]  <= min2(min2(win_i[c], win_i[3 + c]), win_i[6 + c]);
      mid_q[c] <= med3(win_i[c], win_i[3 + c], win_i[6 + c]);
      hi_q[c]  <= max2(max2(win_i[c], win_i[3 + c]), win_i[6 + c]);
    end
    ctr_a_q <= win_i[4];
  end

  // stage B: largest low, median of middles, smallest high
  always_ff @(posedge clk_i) begin
    mx_q    <= max2(max2(lo_q[0], lo_q[1]), lo_q[2]);
    md_q    <= med3(mid_q[0], mid_q[1], mid_q[2]);
    mn_q    <= min2(min2(hi_q[0], hi_q[1]), hi_q[2]);
    ctr_b_q <= ctr_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  // border positions pass the center pixel through
  assign wr_o             = tag_b_q.valid;
  assign word_o.pixel_out = tag_b_q.border ? ctr_b_q : med3(mx_q, md_q, mn_q);
  assign word_o.frame_end = tag_b_q.last;

endmodule

/* hdl/mf3_out_fifo.sv */
// Output word buffer; absorbs words in flight while the output side stalls.
// Depends on mf3_pkg and mf3_out_if.
module mf3_out_fifo import mf3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  out_word_t  word_i,
  output logic       room_o,
  mf3_out_if.source  out_s
);

  localparam int AW   = $clog2(OUT_FIFO_DEPTH);
  localparam int CNTW = $clog2(OUT_FIFO_DEPTH + 1);

  out_word_t       mem [OUT_FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            rd;

  assign rd              = out_s.valid && out_s.ready;
  assign out_s.valid     = (cnt_q != '0);
  assign out_s.pixel_out = mem[rd_ptr_q].pixel_out;
  assign out_s.frame_end = mem[rd_ptr_q].frame_end;
  // keep space for every word the pipeline may still deliver
  assign room_o          = (cnt_q < CNTW'(OUT_FIFO_DEPTH - PIPE_SLOTS));

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_ptr_q] <= word_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!wr_i && rd) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == AW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
    end
  end

endmodule

/* hdl/median_filter_3x3_unit.sv */
// Streaming 3x3 median filter, top level. One input word per clock sustained while the output buffer has room.
// A result word follows the input word that completes its neighborhood (lag of width+1 raster
// positions) through the line read, window and two sort stage registers into the output buffer.
// Stalls on the output side throttle input only once the 8-word output buffer holds 3 words.
// rst_ni is asynchronous, active low: counters, window and pipeline tags clear, size 640x480.
// Line memories are not cleared; every entry used is written earlier in the same frame.
module median_filter_3x3_unit import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mf3_in_if.sink                in_i,
  mf3_out_if.source             out_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  step_t         step;
  logic [CW-1:0] col;
  logic          room;
  win_t          win;
  tag_t          tag;
  logic          word_wr;
  out_word_t     word;

  mf3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_i),
    .room_i     (room),
    .step_o     (step),
    .col_o      (col)
  );

  mf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .col_i  (col),
    .win_o  (win),
    .tag_o  (tag)
  );

  mf3_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win),
    .tag_i  (tag),
    .wr_o   (word_wr),
    .word_o (word)
  );

  mf3_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (word_wr),
    .word_i (word),
    .room_o (room),
    .out_s  (out_o)
  );

endmodule

/* sim/median_filter_3x3_unit_test.sv */
// Self-checking testbench for median_filter_3x3_unit: directed corner cases, size limits,
// output back-pressure and random frames, checked word by word against an internal predictor.
// Depends on mf3_pkg, the mf3 stream interfaces and the median_filter_3x3_unit RTL.
module median_filter_3x3_unit_test;
  import mf3_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int MAX_W           = 2048;
  localparam int MAX_H           = 2048;
  localparam int RING_DEPTH      = 2 * MAX_W + 4;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_WORDS    = 150;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mf3_in_if  in_if ();
  mf3_out_if out_if ();

  median_filter_3x3_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // stimulus knobs; stall percentage and hold-off request are sampled by the sink process
  int unsigned src_idle_pct   = 25;
  int unsigned sink_stall_pct = 68;
  logic        hold_off_flip  = 1'b0;

  // test-side view of the effective frame size and progress of the random part
  int unsigned cur_w        = WIDTH_RST;
  int unsigned cur_h        = HEIGHT_RST;
  int unsigned useful_words = 0;

  // predictor state
  pix_t                  ring_px [RING_DEPTH] = '{default: '0};
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(WIDTH_RST);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RST);
  int unsigned           src_col = 0, src_row = 0, dst_col = 0, dst_row = 0;
  out_word_t             expected_px [$];

  int mismatches  = 0;
  int quiet_cycles = 0;

  function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v, input int unsigned top);
    int unsigned d;
    d = v;
    if (d < MIN_DIM) d = MIN_DIM;
    if (d > top) d = top;
    return d;
  endfunction

  // Filtered word at the current output position; advances the output position
  function automatic out_word_t next_output(input int unsigned w, input int unsigned h);
    out_word_t   o;
    pix_t        nb [9];
    int unsigned below, level;
    logic        at_end;
    at_end = (dst_row == h - 1) && (dst_col == w - 1);
    if (dst_row == 0 || dst_col == 0 || dst_row >= h - 1 || dst_col >= w - 1) begin
      o.pixel_out = ring_px[(dst_row * w + dst_col) % RING_DEPTH];
    end else begin
      for (int i = 0; i < 9; i++)
        nb[i] = ring_px[((dst_row - 1 + i / 3) * w + dst_col - 1 + i % 3) % RING_DEPTH];
      // the median has at most four smaller values and at least five not larger
      o.pixel_out = nb[0];
      for (int i = 0; i < 9; i++) begin
        below = 0;
        level = 0;
        for (int j = 0; j < 9; j++) begin
          if (nb[j] < nb[i]) below++;
          if (nb[j] <= nb[i]) level++;
        end
        if (below <= 4 && level > 4) o.pixel_out = nb[i];
      end
    end
    o.frame_end = at_end;
    if (at_end) begin
      src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    end else if (dst_col + 1 >= w) begin
      dst_col = 0;
      dst_row++;
    end else begin
      dst_col++;
    end
    return o;
  endfunction

  // Queue the result that one accepted input word causes, if any
  function automatic void filter_predict(input opcode_e op, input pix_t px);
    int unsigned w, h, rcvd, sent;
    logic        done;
    w    = eff_dim(width_reg, MAX_W);
    h    = eff_dim(height_reg, MAX_H);
    done = src_row >= h;
    rcvd = done ? h * w : src_row * w + src_col;
    sent = dst_row * w + dst_col;
    if (op == OP_DRAIN) begin
      if (done && sent < rcvd) expected_px.push_back(next_output(w, h));
    end else if (!done) begin
      ring_px[rcvd % RING_DEPTH] = px;
      if (src_col + 1 >= w) begin
        src_col = 0;
        src_row++;
      end else begin
        src_col++;
      end
      if (rcvd >= w + 1) expected_px.push_back(next_output(w, h));
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
  endfunction

  // Scoreboard: register writes and input words feed the predictor, output words are checked
  always @(posedge clk_i) begin : scoreboard
    out_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
      end
      if (in_if.valid && in_if.ready)
        filter_predict(opcode_e'(in_if.opcode), in_if.pixel_in);
      if (out_if.valid && out_if.ready) begin
        if (expected_px.size() == 0) begin
          note_mismatch($sformatf("unexpected word pixel_out=%0d frame_end=%0b",
                                  out_if.pixel_out, out_if.frame_end));
        end else begin
          want = expected_px.pop_front();
          if (out_if.pixel_out !== want.pixel_out)
            note_mismatch($sformatf("pixel_out expected %0d got %0d",
                                    want.pixel_out, out_if.pixel_out));
          if (out_if.frame_end !== want.frame_end)
            note_mismatch($sformatf("frame_end expected %0b got %0b",
                                    want.frame_end, out_if.frame_end));
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sink side: random stalls, plus a long hold-off each time hold_off_flip toggles
  initial begin : sink_side
    logic        seen;
    int unsigned stall_left;
    seen       = 1'b0;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_flip != seen) begin
        seen       = hold_off_flip;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one word, with a random gap first; valid stays high for a following word
  task automatic send_word(input opcode_e op, input pix_t px);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.pixel_in <= px;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop offering and wait until every expected word has come out, then let the pipe settle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (expected_px.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) cur_w = eff_dim(val, MAX_W);
    else cur_h = eff_dim(val, MAX_H);
  endtask

  // Whole frame then its drains; the noisy form adds early drains, extra pixels and a spare drain
  task automatic send_frame(input bit noisy);
    int unsigned n;
    n = cur_w * cur_h;
    for (int unsigned k = 0; k < n; k++) begin
      if (noisy && $urandom_range(7) == 0) send_word(OP_DRAIN, pix_t'($urandom_range(255)));
      send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    end
    if (noisy) repeat ($urandom_range(1, 3)) send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    repeat (cur_w + 1) send_word(OP_DRAIN, pix_t'($urandom_range(255)));
    if (noisy) send_word(OP_DRAIN, pix_t'($urandom_range(255)));
    useful_words += n + cur_w + 1;
  endtask

  // Cut-off frame with stray drains; the caller restarts the frame afterwards
  task automatic send_partial();
    int unsigned n;
    n = $urandom_range(cur_w * cur_h - 1);
    repeat (n) send_word(($urandom_range(5) == 0) ? OP_DRAIN : OP_PIXEL,
                         pix_t'($urandom_range(255)));
    useful_words += n;
  endtask

  // Default size after reset: the first row comes out unfiltered after 641 pixels
  task automatic test_reset_size();
    send_word(OP_DRAIN, pix_t'($urandom_range(255)));
    repeat (cur_w + 5) send_word(OP_PIXEL, pix_t'($urandom_range(255)));
  endtask

  // Smallest frame: early drain, extreme pixels, dropped pixel, flagged last word, idle drain
  task automatic test_corner_cases();
    pix_t corner [9] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00};
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
    send_word(OP_DRAIN, 8'hFF);
    foreach (corner[k]) send_word(OP_PIXEL, corner[k]);
    send_word(OP_PIXEL, 8'hAA);
    repeat (4) send_word(OP_DRAIN, 8'h55);
    send_word(OP_DRAIN, 8'h00);
  endtask

  // Register write in the middle of a frame throws away the pending words
  task automatic test_restart();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(4));
    repeat (12) send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(6));
    send_frame(1'b0);
  endtask

  // Long receiver hold-off while pixels keep coming, so the output buffer fills
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(16));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(8));
    for (int k = 0; k < 16 * 8; k++) begin
      if (k == 40) hold_off_flip <= ~hold_off_flip;
      send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    end
    repeat (17) send_word(OP_DRAIN, pix_t'($urandom_range(255)));
  endtask

  // Random frames in three idling phases: sink-heavy, source-heavy, none
  task automatic test_random_frames();
    int unsigned           idle_src  [3] = '{25, 68, 0};
    int unsigned           idle_sink [3] = '{68, 25, 0};
    int unsigned           pick;
    logic [CFG_DATA_W-1:0] val;
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = idle_src[p];
      sink_stall_pct <= idle_sink[p];
      useful_words = 0;
      while (useful_words < RANDOM_WORDS / 3) begin
        pick = $urandom_range(9);
        // new size now and then, sometimes only one of the two registers
        if (pick < 3) begin
          if (pick != 2) begin
            case ($urandom_range(9))
              0:       val = CFG_DATA_W'($urandom_range(2));
              1:       val = CFG_DATA_W'($urandom_range(11, 32));
              default: val = CFG_DATA_W'($urandom_range(3, 10));
            endcase
            write_reg(CFG_FRAME_WIDTH, val);
          end
          if (pick != 1) begin
            val = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                           : CFG_DATA_W'($urandom_range(3, 7));
            write_reg(CFG_FRAME_HEIGHT, val);
          end
        end
        if (pick == 9) begin
          send_partial();
          write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(3, 7)));
        end else begin
          send_frame(pick == 8);
        end
      end
    end
  endtask

  // Widest and tallest sizes, both given beyond the limit so they clamp; start of frame only
  task automatic test_size_limits();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    repeat (40) send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    send_word(OP_DRAIN, pix_t'($urandom_range(255)));
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_FRAME_HEIGHT, '1);
    repeat (60) send_word(OP_PIXEL, pix_t'($urandom_range(255)));
    send_word(OP_DRAIN, pix_t'($urandom_range(255)));
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.opcode   = OP_PIXEL;
    in_if.pixel_in = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_corner_cases();
    test_restart();
    test_backpressure();
    test_random_frames();
    test_size_limits();

    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mf3_pkg.sv
hdl/mf3_stream_if.sv
hdl/mf3_ctrl.sv
hdl/mf3_line_store.sv
hdl/mf3_median.sv
hdl/mf3_out_fifo.sv
hdl/median_filter_3x3_unit.sv
sim/median_filter_3x3_unit_test.sv
